// File: src/ordq_pkg.sv
// ============================================================================
// ordq_pkg
// Shared constants, types and pointer helpers for the overwriting ring deque.
// ============================================================================
package ordq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Operation codes carried on the mode field
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [2:0] MODE_POP_BACK   = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [2:0] MODE_READ       = 3'd4;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// Ring position: front slot, back slot and number of entries held
	typedef struct packed {
		ptr_t head;
		ptr_t tail;
		cnt_t fill;
	} ring_t;

	// Outcome of one operation: new ring position, store write and status
	typedef struct packed {
		ring_t ring;
		logic  wr_en;
		ptr_t  wr_addr;
		word_t wr_data;
		logic  err;
	} step_t;

	// Advance a pointer by one, wrapping at the capacity
	function automatic ptr_t ring_up(ptr_t p, cnt_t cap);
		cnt_t nxt;
		nxt = CNT_W'(p) + CNT_W'(1);
		return (nxt >= cap) ? '0 : PTR_W'(nxt);
	endfunction

	// Move a pointer back by one, wrapping at the capacity
	function automatic ptr_t ring_down(ptr_t p, cnt_t cap);
		return (p == '0) ? PTR_W'(cap - CNT_W'(1)) : p - PTR_W'(1);
	endfunction

	// Clamp a written capacity to 1..DEPTH
	function automatic cnt_t clamp_cap(logic [4:0] v);
		cnt_t r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > DEPTH) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

// File: src/ordq_ram.sv
// ============================================================================
// ordq_ram
// Generic RAM: one write port, two read ports, registered read (read-first).
// ============================================================================
module ordq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register both read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: src/ordq_step.sv
// ============================================================================
// ordq_step
// Next ring position, store write and error flag for one operation.
// ============================================================================
module ordq_step import ordq_pkg::*; (
	input  logic [2:0] mode,
	input  word_t      value,
	input  logic [3:0] index,
	input  cnt_t       cap,
	input  ring_t      cur,
	output step_t      nxt
);

	always_comb begin
		nxt         = '0;
		nxt.ring    = cur;
		nxt.wr_en   = 1'b0;
		nxt.wr_addr = cur.head;
		nxt.wr_data = '0;
		nxt.err     = 1'b0;
		case (mode)
			MODE_PUSH_BACK: begin
				// advance back; drop the oldest entry when full
				nxt.ring.tail = ring_up(cur.tail, cap);
				nxt.wr_en     = 1'b1;
				nxt.wr_addr   = nxt.ring.tail;
				nxt.wr_data   = value;
				if (cur.fill < cap) begin
					nxt.ring.fill = cur.fill + CNT_W'(1);
				end else begin
					nxt.ring.head = ring_up(cur.head, cap);
				end
			end
			MODE_PUSH_FRONT: begin
				// step front back; drop the newest entry when full
				nxt.ring.head = ring_down(cur.head, cap);
				nxt.wr_en     = 1'b1;
				nxt.wr_addr   = nxt.ring.head;
				nxt.wr_data   = value;
				if (cur.fill < cap) begin
					nxt.ring.fill = cur.fill + CNT_W'(1);
				end else begin
					nxt.ring.tail = ring_down(cur.tail, cap);
				end
			end
			MODE_POP_BACK: begin
				if (cur.fill == '0) begin
					nxt.err = 1'b1;
				end else begin
					nxt.wr_en     = 1'b1;
					nxt.wr_addr   = cur.tail;
					nxt.ring.tail = ring_down(cur.tail, cap);
					nxt.ring.fill = cur.fill - CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (cur.fill == '0) begin
					nxt.err = 1'b1;
				end else begin
					nxt.wr_en     = 1'b1;
					nxt.wr_addr   = cur.head;
					nxt.ring.head = ring_up(cur.head, cap);
					nxt.ring.fill = cur.fill - CNT_W'(1);
				end
			end
			MODE_READ: begin
				nxt.err = (int'(index) >= int'(cap));
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/overwriting_ring_deque.sv
// ============================================================================
// overwriting_ring_deque
// Double-ended ring buffer with overwrite on full, store held in a RAM.
// ============================================================================
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_ready    | mode, value, index
//  out     | out_valid / out_ready  | read_data, front_value, back_value, count,
//          |                        | is_empty, is_full, error
//  cfg     | cfg_we (no wait)       | cfg_wdata (capacity)
//
//  Each item passes three steps: accept (store write, slot read), head/tail
//  read, result capture. The single RAM write port and its registered read
//  set this sequence; the next item is taken after capture.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile and stalls in capture until the register frees.
//  Reset clears the store through per-slot valid bits; no clearing pass.
//
module overwriting_ring_deque import ordq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] value,
	input  logic [3:0]  index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [31:0] front_value,
	output logic [31:0] back_value,
	output logic [4:0]  count,
	output logic        is_empty,
	output logic        is_full,
	output logic        error,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]       state_q;
	ring_t            ring_q;
	cnt_t             cap_q;
	logic [DEPTH-1:0] vld_q;
	step_t            nxt;
	logic             acc;
	logic             load;
	ptr_t             raddr_a;
	word_t            rdata_a;
	word_t            rdata_b;
	logic             vld_a_s1;
	logic [2:0]       mode_s1;
	logic             err_s1;
	word_t            rd_s1;

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [31:0] front_q;
	logic [31:0] back_q;
	logic [4:0]  count_q;
	logic        empty_q;
	logic        full_q;
	logic        error_q;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign load     = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	ordq_step u_step (
		.mode  (mode),
		.value (value[DATA_WIDTH-1:0]),
		.index (index),
		.cap   (cap_q),
		.cur   (ring_q),
		.nxt   (nxt)
	);

	// Slot read on accept, head and tail afterwards
	assign raddr_a = (state_q == ST_IDLE) ? PTR_W'(index) : ring_q.head;

	ordq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (acc && nxt.wr_en),
		.waddr   (nxt.wr_addr),
		.wdata   (nxt.wr_data),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (ring_q.tail),
		.rdata_b (rdata_b)
	);

	// Track the valid bit alongside the port A read
	always_ff @(posedge clk) begin
		vld_a_s1 <= vld_q[raddr_a];
	end

	// Sequencer, ring position and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ring_q  <= '{head: '0, tail: PTR_W'(DEPTH - 1), fill: '0};
			cap_q   <= CNT_W'(DEPTH);
			vld_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						ring_q  <= nxt.ring;
						state_q <= ST_RD;
						if (nxt.wr_en) begin
							vld_q[nxt.wr_addr] <= 1'b1;
						end
					end else if (cfg_we && ring_q.fill == '0) begin
						cap_q       <= clamp_cap(cfg_wdata);
						ring_q.head <= '0;
						ring_q.tail <= PTR_W'(clamp_cap(cfg_wdata) - CNT_W'(1));
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold per-item status; capture the slot read in the cycle after accept
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= mode;
			err_s1  <= nxt.err;
		end
		if (state_q == ST_RD) begin
			rd_s1 <= (mode_s1 == MODE_READ && !err_s1 && vld_a_s1) ? rdata_a : '0;
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (load) begin
			read_data_q <= 32'(rd_s1);
			front_q     <= (ring_q.fill != '0 && vld_a_s1) ? 32'(rdata_a) : '0;
			back_q      <= (ring_q.fill != '0) ? 32'(rdata_b) : '0;
			count_q     <= 5'(ring_q.fill);
			empty_q     <= (ring_q.fill == '0);
			full_q      <= (ring_q.fill == cap_q);
			error_q     <= err_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign error       = error_q;

	// Fill never exceeds the capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q.fill <= cap_q)
		else $error("fill above capacity");

	// Both ends stay inside the capacity
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_q.head < PTR_W'(cap_q) || cap_q == CNT_W'(DEPTH)) &&
		(ring_q.tail < PTR_W'(cap_q) || cap_q == CNT_W'(DEPTH)))
		else $error("pointer beyond capacity");

	// An empty ring keeps the back one slot before the front
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q.fill == '0 |-> ring_q.tail == ring_down(ring_q.head, cap_q))
		else $error("empty ring with misplaced ends");

	// A stalled result keeps the next item parked in capture
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && !out_ready |=> state_q == ST_OUT)
		else $error("capture left while output stalled");

endmodule

// File: sim/overwriting_ring_deque_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_ring_deque_tb
// Drives operation beats into the ring deque under random idling on both
// channels and checks every status beat against a cycle-free deque model.
// ----------------------------------------------------------------------------
module overwriting_ring_deque_tb;
	import ordq_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYC  = 8;

	// Status reported for one operation, in port order
	typedef struct packed {
		word_t      rd;
		word_t      front;
		word_t      back;
		logic [4:0] cnt;
		logic       empty;
		logic       full;
		logic       err;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = '0;
	logic [31:0] value = '0;
	logic [3:0]  index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic [31:0] front_value;
	logic [31:0] back_value;
	logic [4:0]  count;
	logic        is_empty;
	logic        is_full;
	logic        error;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	// Deque model state
	word_t       store [DEPTH];
	int          head_q = 0;
	int          tail_q = DEPTH - 1;
	int          fill_q = 0;
	int          ring_cap = DEPTH;

	status_t     status_q [$];
	bit          calm = 1'b0;
	int          mismatches = 0;
	int          quiet = 0;

	overwriting_ring_deque DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.value      (value),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.front_value(front_value),
		.back_value (back_value),
		.count      (count),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.error      (error),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) store[i] = '0;
	end

	function automatic int pos_up(int p);
		return (p + 1 >= ring_cap) ? 0 : p + 1;
	endfunction

	function automatic int pos_down(int p);
		return (p == 0) ? ring_cap - 1 : p - 1;
	endfunction

	// Apply one operation to the model and return the status it reports
	function automatic status_t ring_predict(logic [2:0] op, word_t val, logic [3:0] idx);
		status_t r;
		r = '0;
		head_q = head_q % ring_cap;
		tail_q = tail_q % ring_cap;
		case (op)
			MODE_PUSH_BACK: begin
				tail_q = pos_up(tail_q);
				store[tail_q] = val;
				if (fill_q < ring_cap) fill_q++;
				else head_q = pos_up(head_q);
			end
			MODE_PUSH_FRONT: begin
				head_q = pos_down(head_q);
				store[head_q] = val;
				if (fill_q < ring_cap) fill_q++;
				else tail_q = pos_down(tail_q);
			end
			MODE_POP_BACK: begin
				if (fill_q == 0) begin
					r.err = 1'b1;
				end else begin
					store[tail_q] = '0;
					tail_q = pos_down(tail_q);
					fill_q--;
				end
			end
			MODE_POP_FRONT: begin
				if (fill_q == 0) begin
					r.err = 1'b1;
				end else begin
					store[head_q] = '0;
					head_q = pos_up(head_q);
					fill_q--;
				end
			end
			MODE_READ: begin
				if (int'(idx) >= ring_cap) r.err = 1'b1;
				else r.rd = store[idx];
			end
			default: ;
		endcase
		r.front = (fill_q != 0) ? store[head_q] : '0;
		r.back  = (fill_q != 0) ? store[tail_q] : '0;
		r.cnt   = 5'(fill_q);
		r.empty = (fill_q == 0);
		r.full  = (fill_q == ring_cap);
		return r;
	endfunction

	// Present one operation beat, hold it until accepted, then record its status
	task automatic send_op(logic [2:0] op, word_t val, logic [3:0] idx);
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= val;
		index    <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		status_q.insert(status_q.size(), ring_predict(op, val, idx));
	endtask

	// Drop valid and wait until every status beat is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write the capacity register; the model ignores it while entries are held
	task automatic capacity_write(logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (fill_q == 0) begin
			ring_cap = (v == '0) ? 1 : ((int'(v) > DEPTH) ? DEPTH : int'(v));
			head_q   = 0;
			tail_q   = ring_cap - 1;
		end
	endtask

	// Empty store after reset: reads, pops on empty, unused modes
	task automatic test_empty_rules();
		send_op(MODE_READ, '0, 4'd0);
		send_op(MODE_READ, '0, 4'd15);
		send_op(MODE_POP_BACK, '1, '0);
		send_op(MODE_POP_FRONT, '1, '1);
		for (int m = int'(MODE_READ) + 1; m < 8; m++) send_op(3'(m), '1, '1);
	endtask

	// Front push into an empty buffer points both ends at the new entry
	task automatic test_front_into_empty();
		send_op(MODE_PUSH_FRONT, 32'hFFFF_FFFF, '0);
		send_op(MODE_POP_BACK, '0, '0);
	endtask

	// Overwrite from both ends at a capacity of two, reads past capacity
	task automatic test_small_overwrite();
		settle();
		capacity_write(5'd2);
		send_op(MODE_PUSH_BACK, 32'h0000_0000, '0);
		send_op(MODE_PUSH_BACK, 32'hFFFF_FFFF, '0);
		send_op(MODE_PUSH_BACK, 32'h5A5A_5A5A, '0);
		send_op(MODE_PUSH_FRONT, 32'hA5A5_A5A5, '0);
		send_op(MODE_READ, '0, 4'd1);
		send_op(MODE_READ, '0, 4'd2);
		send_op(MODE_READ, '0, 4'd15);
		send_op(MODE_POP_FRONT, '0, '0);
		send_op(MODE_POP_BACK, '0, '0);
		send_op(MODE_POP_BACK, '0, '0);
	endtask

	// Capacity write while entries are held must not take effect
	task automatic test_locked_capacity();
		send_op(MODE_PUSH_BACK, 32'h0000_0001, '0);
		settle();
		capacity_write(5'd7);
		send_op(MODE_READ, '0, 4'd5);
		send_op(MODE_POP_FRONT, '0, '0);
	endtask

	// Random operation with a given share of pushes
	task automatic send_random(int push_pct);
		int          pick;
		logic [2:0]  op;
		word_t       val;
		pick = $urandom_range(99);
		if (pick < push_pct)
			op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		else if (pick < 85)
			op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
		else if (pick < 97)
			op = MODE_READ;
		else
			op = 3'($urandom_range(7, int'(MODE_READ) + 1));
		case ($urandom_range(9))
			0: val = '0;
			1: val = '1;
			default: val = $urandom;
		endcase
		send_op(op, val, 4'($urandom_range(15)));
	endtask

	// Random phases, each at its own capacity, one phase without idling
	task automatic test_random();
		logic [4:0] caps [12] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17,
		                          5'd2, 5'd12, 5'd3, 5'd16, 5'd8, 5'd4};
		int         push_pct;
		push_pct = 50;
		foreach (caps[p]) begin
			while (fill_q != 0)
				send_op($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, '0, '0);
			settle();
			capacity_write(caps[p]);
			calm = (p == 4);
			for (int i = 0; i < 110; i++) begin
				if (i % 20 == 0) push_pct = $urandom_range(75, 25);
				send_random(push_pct);
			end
			calm = 1'b0;
		end
	endtask

	// Receiver: stall at random unless in the calm phase
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 20);
	end

	// Compare each status beat with the oldest expected one
	always @(posedge clk) begin
		status_t seen;
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {read_data, front_value, back_value, count, is_empty, is_full, error};
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected status beat: rd=%h front=%h back=%h cnt=%0d",
					         seen.rd, seen.front, seen.back, seen.cnt);
			end else begin
				want = status_q[0];
				status_q.delete(0);
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: rd=%h front=%h back=%h cnt=%0d e=%b f=%b err=%b",
						         want.rd, want.front, want.back, want.cnt,
						         want.empty, want.full, want.err);
						$display("         got: rd=%h front=%h back=%h cnt=%0d e=%b f=%b err=%b",
						         seen.rd, seen.front, seen.back, seen.cnt,
						         seen.empty, seen.full, seen.err);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("overwriting_ring_deque_tb failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_rules();
		test_front_into_empty();
		test_small_overwrite();
		test_locked_capacity();
		test_random();
		settle();
		if (mismatches == 0) begin
			$display("overwriting_ring_deque_tb passed");
		end else begin
			$display("overwriting_ring_deque_tb failed");
		end
		$finish;
	end

endmodule
